[rtl/hsss_pkg.sv]
package hsss_pkg;

	localparam int PHASES = 8;
	localparam int PHASE_W = $clog2(PHASES);
	localparam int STEPS_W = 16;
	localparam int PULSE_W = 16;
	localparam int NSTEP_W = 15;
	localparam int COIL_W = 4;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_TICK  = 2'd1,
		OP_ENC_A = 2'd2,
		OP_ENC_B = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ABORT = 2'd2
	} status_t;

	typedef struct packed {
		logic [COIL_W-1:0] coils;
		logic              busy;
		status_t           status;
	} res_t;

	// half-step coil patterns, IN4..IN1, phases 1 to 8
	localparam logic [COIL_W-1:0] COIL_PATTERN [PHASES] = '{
		4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
	};

endpackage

[rtl/hsss_core.sv]
module hsss_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  hsss_pkg::op_t                 op,
	input  logic [hsss_pkg::NSTEP_W-1:0] num_steps,
	input  logic                          direction,
	input  logic                          chan_a_level,
	output hsss_pkg::res_t                res
);
	import hsss_pkg::*;

	logic [PHASE_W-1:0]        phase_q, phase_n;
	logic signed [STEPS_W-1:0] steps_q, steps_n, steps_adv;
	logic [PULSE_W-1:0]        pulse_q, pulse_n;
	logic                      mdir_q, mdir_n;
	logic                      cdir_q, cdir_n;
	logic                      moving_q, moving_n;
	logic [COIL_W-1:0]         coil_q, coil_n;
	status_t                   status_n;
	logic                      wrap, take_step, add_back, abort;

	// phase advance for a tick of a running move
	always_comb begin
		wrap = cdir_q ? (phase_q == '0) : (phase_q == PHASE_W'(PHASES - 1));
		take_step = 1'b0;
		add_back = 1'b0;
		abort = 1'b0;
		pulse_n = pulse_q;
		phase_n = phase_q;
		if (wrap) begin
			phase_n = cdir_q ? PHASE_W'(PHASES - 1) : '0;
			if (pulse_q == '0) begin
				add_back = 1'b1;
			end else begin
				// counterclockwise wrap counts no step
				take_step = !cdir_q;
				pulse_n = '0;
				abort = (cdir_q != mdir_q);
			end
		end else begin
			take_step = phase_q[0];
			phase_n = cdir_q ? (phase_q - 1'b1) : (phase_q + 1'b1);
		end
		steps_adv = steps_q;
		if (take_step && steps_q != {1'b1, {(STEPS_W-1){1'b0}}})
			steps_adv = steps_q - 16'sd1;
		else if (add_back && steps_q != {1'b0, {(STEPS_W-1){1'b1}}})
			steps_adv = steps_q + 16'sd1;
	end

	always_comb begin
		steps_n = steps_q;
		mdir_n = mdir_q;
		cdir_n = cdir_q;
		moving_n = moving_q;
		coil_n = coil_q;
		status_n = ST_NONE;
		res.coils = coil_q;
		case (op)
			OP_START: begin
				steps_n = STEPS_W'({1'b0, num_steps});
				cdir_n = direction;
				mdir_n = direction;
				moving_n = (num_steps != '0);
				if (num_steps == '0)
					status_n = ST_DONE;
			end
			OP_TICK: begin
				if (moving_q) begin
					coil_n = COIL_PATTERN[phase_q];
					steps_n = steps_adv;
					if (abort) begin
						moving_n = 1'b0;
						status_n = ST_ABORT;
					end else if (steps_adv[STEPS_W-1] || steps_adv == '0) begin
						moving_n = 1'b0;
						status_n = ST_DONE;
					end
				end
			end
			OP_ENC_A: begin
			end
			OP_ENC_B: begin
				mdir_n = !chan_a_level;
			end
			default: begin
			end
		endcase
		res.coils = coil_n;
		res.busy = moving_n;
		res.status = status_n;
	end

	wire tick_run = (op == OP_TICK) && moving_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			steps_q <= '0;
			pulse_q <= '0;
			mdir_q <= 1'b0;
			cdir_q <= 1'b0;
			moving_q <= 1'b0;
			coil_q <= '0;
		end else if (fire) begin
			steps_q <= steps_n;
			mdir_q <= mdir_n;
			cdir_q <= cdir_n;
			moving_q <= moving_n;
			coil_q <= coil_n;
			if (tick_run) begin
				phase_q <= phase_n;
				pulse_q <= pulse_n;
			end else if (op == OP_ENC_A && pulse_q != {PULSE_W{1'b1}}) begin
				// saturate at full scale
				pulse_q <= pulse_q + 1'b1;
			end
		end
	end

	a_zero_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == OP_START && num_steps == '0 |=> !moving_q)
		else $error("zero-step start left the move running");

	a_idle_tick_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == OP_TICK && !moving_q |=> $stable(coil_q) && $stable(phase_q))
		else $error("tick while idle changed coils or phase");

	a_abort_stops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.status == ST_ABORT |=> !moving_q)
		else $error("abort did not stop the move");

	a_pulse_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == OP_ENC_A && pulse_q != {PULSE_W{1'b1}}
		|=> pulse_q == $past(pulse_q) + 1'b1)
		else $error("encoder pulse not counted");

endmodule

[rtl/half_step_stepper_sequencer.sv]
// An accepted input item passes through the input register, then the result register, before
// its result appears on the master side.
// Throughput: one item per cycle; the input register advances whenever the result
// register is empty or being taken.
// Reset: arst_n clears all move state, phase to phase 1, coils off, both stages empty.
module half_step_stepper_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // num_steps[14:0], direction[15], chan_a_level[16]
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // coils[3:0], busy_res[4], status[6:5]
);
	import hsss_pkg::*;

	logic               valid_s1;
	op_t                op_s1;
	logic [NSTEP_W-1:0] num_steps_s1;
	logic               direction_s1;
	logic               chan_a_s1;
	logic               valid_s2;
	res_t               res_s2;
	res_t               res;
	logic               adv;

	assign adv = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	hsss_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (adv),
		.op           (op_s1),
		.num_steps    (num_steps_s1),
		.direction    (direction_s1),
		.chan_a_level (chan_a_s1),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= op_t'(s_tuser);
			num_steps_s1 <= s_tdata[14:0];
			direction_s1 <= s_tdata[15];
			chan_a_s1 <= s_tdata[16];
		end
		if (adv)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {1'b0, res_s2.status, res_s2.busy, res_s2.coils};

endmodule
